// ===== sv/mcsfs_pkg.sv =====
// Package for the multi-chip SPI flash sequencer: command, opcode, data
// phase and register index codes, plus reset values. No dependencies.
package mcsfs_pkg;

  // Chips that have size and select registers
  localparam int unsigned REG_CHIPS = 4;

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_PROGRAM = 2'd1,
    CMD_ERASE   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  localparam logic [7:0] OP_RDSR = 8'h05;
  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_READ = 8'h03;
  localparam logic [7:0] OP_PP   = 8'h02;
  localparam logic [7:0] OP_SE   = 8'hd8;

  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_SEND = 2'd1;
  localparam logic [1:0] PHASE_RECV = 2'd2;
  localparam logic [1:0] PHASE_POLL = 2'd3;

  localparam logic [2:0] REG_CHIP_COUNT = 3'd0;
  localparam logic [2:0] REG_SECTORS0   = 3'd1;
  localparam logic [2:0] REG_SECTORS1   = 3'd2;
  localparam logic [2:0] REG_SECTORS2   = 3'd3;
  localparam logic [2:0] REG_SECTORS3   = 3'd4;
  localparam logic [2:0] REG_SELECT     = 3'd5;

  localparam logic [31:0] SELECT_RESET = 32'h0804_0201;

endpackage

// ===== sv/multi_chip_spi_flash_sequencer.sv =====
// Multi-chip SPI NOR flash command sequencer, top level.
// Depends on mcsfs_pkg for codes and reset values.
//
// One request (read page, program page, erase sector) is taken at a time.
// After the accept cycle a single compare/subtract unit walks the chips, one
// chip per cycle: the page's sector is compared against the chip size and,
// if at or past it, the chip's pages are subtracted and the walk moves on.
// Then one descriptor item leaves per cycle through the output register
// while the output side does not stall: an optional status poll, an
// optional write enable, and the command. An address past all chips
// yields one range error item instead. cmd 3 is accepted and dropped.
// Configuration writes are always taken (cfg_ready_o is tied high) and
// must only happen while the block is idle.
module multi_chip_spi_flash_sequencer
  import mcsfs_pkg::*;
#(
  parameter int unsigned MAX_CHIPS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] page_i,
  input  logic [7:0]  sector_i,
  // descriptor channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  chip_line_o,
  output logic [7:0]  opcode_o,
  output logic [23:0] flash_address_o,
  output logic        has_address_o,
  output logic [1:0]  data_phase_o,
  output logic        range_error_o,
  output logic        last_o
);

  // chips actually walkable: parameter limit and register limit
  localparam int unsigned NChips = (MAX_CHIPS < REG_CHIPS) ? MAX_CHIPS : REG_CHIPS;
  localparam int unsigned CntW   = $clog2(NChips + 1);
  localparam int unsigned IdxW   = (NChips > 1) ? $clog2(NChips) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_POLL = 6'b000100,
    S_WREN = 6'b001000,
    S_CMD  = 6'b010000,
    S_ERR  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [2:0]                 chip_count_q;
  logic [REG_CHIPS-1:0][7:0]  sectors_q;
  logic [REG_CHIPS-1:0][7:0]  select_q;

  // request context
  cmd_e            cmd_q, cmd_d;
  logic [15:0]     page_q, page_d;
  logic [CntW-1:0] chip_q, chip_d;
  logic [7:0]      line_q, line_d;
  logic [7:0]      busy_q, busy_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  line_out_q, line_out_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [23:0] addr_q, addr_d;
  logic        has_addr_q, has_addr_d;
  logic [1:0]  phase_q, phase_d;
  logic        err_q, err_d;
  logic        last_q, last_d;

  logic       out_free;
  logic       emit;
  logic [2:0] limit;
  logic [7:0] size;
  logic [7:0] sel_byte;
  logic [IdxW-1:0] idx;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  assign limit    = (chip_count_q > 3'(NChips)) ? 3'(NChips) : chip_count_q;
  assign idx      = chip_q[IdxW-1:0];
  assign size     = sectors_q[idx];
  assign sel_byte = select_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_count_q <= '0;
      sectors_q    <= '0;
      select_q     <= SELECT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CHIP_COUNT: chip_count_q <= cfg_data_i[2:0];
        REG_SECTORS0:   sectors_q[0] <= cfg_data_i[7:0];
        REG_SECTORS1:   sectors_q[1] <= cfg_data_i[7:0];
        REG_SECTORS2:   sectors_q[2] <= cfg_data_i[7:0];
        REG_SECTORS3:   sectors_q[3] <= cfg_data_i[7:0];
        REG_SELECT:     select_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    page_d     = page_q;
    chip_d     = chip_q;
    line_d     = line_q;
    busy_d     = busy_q;
    emit       = 1'b0;
    line_out_d = line_out_q;
    opcode_d   = opcode_q;
    addr_d     = addr_q;
    has_addr_d = has_addr_q;
    phase_d    = phase_q;
    err_d      = err_q;
    last_d     = last_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && cmd_i != CMD_NONE) begin
          cmd_d   = cmd_e'(cmd_i);
          page_d  = (cmd_i == CMD_ERASE) ? {sector_i, 8'h00} : page_i;
          chip_d  = '0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        // one compare and one subtract per chip
        if (3'(chip_q) >= limit) begin
          state_d = S_ERR;
        end else if (page_q[15:8] < size) begin
          line_d = sel_byte;
          if ((busy_q & sel_byte) != 8'h00) state_d = S_POLL;
          else if (cmd_q != CMD_READ)       state_d = S_WREN;
          else                              state_d = S_CMD;
        end else begin
          page_d = page_q - {size, 8'h00};
          chip_d = chip_q + CntW'(1);
        end
      end
      S_POLL: begin
        if (out_free) begin
          emit       = 1'b1;
          line_out_d = line_q;
          opcode_d   = OP_RDSR;
          addr_d     = '0;
          has_addr_d = 1'b0;
          phase_d    = PHASE_POLL;
          err_d      = 1'b0;
          last_d     = 1'b0;
          busy_d     = busy_q & ~line_q;
          state_d    = (cmd_q != CMD_READ) ? S_WREN : S_CMD;
        end
      end
      S_WREN: begin
        if (out_free) begin
          emit       = 1'b1;
          line_out_d = line_q;
          opcode_d   = OP_WREN;
          addr_d     = '0;
          has_addr_d = 1'b0;
          phase_d    = PHASE_NONE;
          err_d      = 1'b0;
          last_d     = 1'b0;
          busy_d     = busy_q | line_q;
          state_d    = S_CMD;
        end
      end
      S_CMD: begin
        if (out_free) begin
          emit       = 1'b1;
          line_out_d = line_q;
          addr_d     = {page_q, 8'h00};
          has_addr_d = 1'b1;
          err_d      = 1'b0;
          last_d     = 1'b1;
          case (cmd_q)
            CMD_READ: begin
              opcode_d = OP_READ;
              phase_d  = PHASE_RECV;
            end
            CMD_PROGRAM: begin
              opcode_d = OP_PP;
              phase_d  = PHASE_SEND;
            end
            default: begin
              opcode_d = OP_SE;
              phase_d  = PHASE_NONE;
            end
          endcase
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          emit       = 1'b1;
          line_out_d = '0;
          opcode_d   = '0;
          addr_d     = '0;
          has_addr_d = 1'b0;
          phase_d    = PHASE_NONE;
          err_d      = 1'b1;
          last_d     = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = (out_valid_q && !out_ready_i) || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
      chip_q      <= '0;
      cmd_q       <= CMD_READ;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      chip_q      <= chip_d;
      cmd_q       <= cmd_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    line_q     <= line_d;
    line_out_q <= line_out_d;
    opcode_q   <= opcode_d;
    addr_q     <= addr_d;
    has_addr_q <= has_addr_d;
    phase_q    <= phase_d;
    err_q      <= err_d;
    last_q     <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign chip_line_o     = line_out_q;
  assign opcode_o        = opcode_q;
  assign flash_address_o = addr_q;
  assign has_address_o   = has_addr_q;
  assign data_phase_o    = phase_q;
  assign range_error_o   = err_q;
  assign last_o          = last_q;

  // walk counter never exceeds the number of walkable chips
  a_chip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chip_q <= CntW'(NChips))
    else $error("chip counter out of range");

  // status poll clears the chosen chip's busy marks
  a_poll_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POLL && out_free) |=> ((busy_q & line_q) == 8'h00))
    else $error("busy marks not cleared by poll");

  // write enable sets the chosen chip's busy marks
  a_wren_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WREN && out_free) |=> ((busy_q & line_q) == line_q))
    else $error("busy marks not set by write enable");

  // an error item closes the request and carries no transaction
  a_err_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (last_q && line_out_q == 8'h00 && !has_addr_q))
    else $error("malformed range error item");

  // the command item returns the sequencer to idle
  a_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMD && out_free) |=> (state_q == S_IDLE && out_valid_q && last_q))
    else $error("command item did not end the request");

endmodule
